### design/fcc_pkg.sv
// fcc_pkg: shared constants, types and helpers for the foot force contact block.
// Used by fcc_front, fcc_queue, fcc_back and foot_force_contact_cop. No dependencies.
package fcc_pkg;

    localparam int MAX_PHYS    = 4;             // physical sensors per foot
    localparam int SENSORS_DEF = 4;
    localparam int FORCE_W     = 16;            // unsigned Q8.8
    localparam int COORD_W     = 16;            // signed Q8.8
    localparam int TOTAL_W     = 18;
    localparam int HULL_W      = MAX_PHYS * COORD_W;
    localparam int SIDX_W      = $clog2(MAX_PHYS);
    localparam int Q_DEPTH     = 2;             // power of two
    localparam int APB_AW      = 5;
    localparam int APB_DW      = 64;

    localparam logic [TOTAL_W-1:0] TOTAL_INF = '1;

    typedef enum logic [1:0] {
        REG_LEFT_X  = 2'd0,
        REG_LEFT_Y  = 2'd1,
        REG_RIGHT_X = 2'd2,
        REG_RIGHT_Y = 2'd3
    } t_reg;

    typedef logic [FORCE_W-1:0] t_force;

    typedef struct packed {
        logic                          sample_valid;
        logic                          foot;
        logic [TOTAL_W-1:0]            total;
        logic                          contact;
        t_force [MAX_PHYS-1:0]         frc;
    } t_item;

    typedef struct packed {
        logic [HULL_W-1:0] x;
        logic [HULL_W-1:0] y;
    } t_hull;

    function automatic int f_used(int sensors);
        return (sensors < MAX_PHYS) ? sensors : MAX_PHYS;
    endfunction

endpackage

### design/foot_force_contact_cop.sv
// foot_force_contact_cop: per-foot force total, contact detection and centre of pressure.
// Path: input register in fcc_front, the queue, then fcc_back and its output register.
// Contact items also run the serial MAC and restoring divider in fcc_back, which takes a new
// item only once the last is done. A 2-entry queue decouples front and back.
// Reset (synchronous, active low): min totals all ones, max totals zero, hull registers zero.
// Depends on fcc_pkg, fcc_front, fcc_queue, fcc_back.
module foot_force_contact_cop #(
    parameter int SENSORS = fcc_pkg::SENSORS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // sample channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_foot,
    input  logic                               i_sample_valid,
    input  logic [fcc_pkg::FORCE_W-1:0]        i_force_0,
    input  logic [fcc_pkg::FORCE_W-1:0]        i_force_1,
    input  logic [fcc_pkg::FORCE_W-1:0]        i_force_2,
    input  logic [fcc_pkg::FORCE_W-1:0]        i_force_3,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_result_valid,
    output logic [fcc_pkg::TOTAL_W-1:0]        o_total_force,
    output logic                               o_contact,
    output logic                               o_cop_valid,
    output logic signed [fcc_pkg::COORD_W-1:0] o_cop_x,
    output logic signed [fcc_pkg::COORD_W-1:0] o_cop_y,
    // APB config port, 64-bit registers at 8-byte spacing
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [fcc_pkg::APB_AW-1:0]         paddr,
    input  logic [fcc_pkg::APB_DW-1:0]         pwdata,
    output logic [fcc_pkg::APB_DW-1:0]         prdata,
    output logic                               pready
);
    import fcc_pkg::*;

    // hull coordinate registers: index 0 is the left foot, 1 the right
    t_hull                  r_hull [2];
    t_hull [1:0]            hull_bus;
    t_reg                   reg_sel;
    logic                   cfg_wr;

    t_force [MAX_PHYS-1:0]  w_frc;
    logic                   w_push, w_pop, w_full, w_empty;
    t_item                  w_f_item, w_q_item;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    // low address bits are ignored; paddr[4:3] picks the register
    assign reg_sel = t_reg'(paddr[4:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hull[0] <= '0;
            r_hull[1] <= '0;
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_LEFT_X:  r_hull[0].x <= pwdata;
                REG_LEFT_Y:  r_hull[0].y <= pwdata;
                REG_RIGHT_X: r_hull[1].x <= pwdata;
                REG_RIGHT_Y: r_hull[1].y <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_LEFT_X:  prdata = r_hull[0].x;
            REG_LEFT_Y:  prdata = r_hull[0].y;
            REG_RIGHT_X: prdata = r_hull[1].x;
            REG_RIGHT_Y: prdata = r_hull[1].y;
            default:     prdata = '0;
        endcase
    end

    assign hull_bus[0] = r_hull[0];
    assign hull_bus[1] = r_hull[1];

    assign w_frc[0] = i_force_0;
    assign w_frc[1] = i_force_1;
    assign w_frc[2] = i_force_2;
    assign w_frc[3] = i_force_3;

    // front: register sample, total it, update min/max, classify contact
    fcc_front #(.SENSORS(SENSORS)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_foot         (i_foot),
        .i_sample_valid (i_sample_valid),
        .i_frc          (w_frc),
        .i_q_full       (w_full),
        .o_push         (w_push),
        .o_item         (w_f_item)
    );

    fcc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_f_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_item  (w_q_item)
    );

    // back: weighted sums over the sensors, then signed divide by the total
    fcc_back #(.SENSORS(SENSORS)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (w_empty),
        .o_pop          (w_pop),
        .i_item         (w_q_item),
        .i_hull         (hull_bus),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_valid (o_result_valid),
        .o_total_force  (o_total_force),
        .o_contact      (o_contact),
        .o_cop_valid    (o_cop_valid),
        .o_cop_x        (o_cop_x),
        .o_cop_y        (o_cop_y)
    );

endmodule

### design/fcc_front.sv
// fcc_front: input register, force total, per-foot min/max tracking and contact test.
// Depends on fcc_pkg.
module fcc_front #(
    parameter int SENSORS = fcc_pkg::SENSORS_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_in_valid,
    output logic                                          o_in_stall,
    input  logic                                          i_foot,
    input  logic                                          i_sample_valid,
    input  fcc_pkg::t_force [fcc_pkg::MAX_PHYS-1:0]       i_frc,
    input  logic                                          i_q_full,
    output logic                                          o_push,
    output fcc_pkg::t_item                                o_item
);
    import fcc_pkg::*;

    localparam int USED = f_used(SENSORS);

    logic                        r_a_vld;
    logic                        r_a_foot;
    logic                        r_a_sv;
    logic [TOTAL_W-1:0]          r_a_total;
    t_force [MAX_PHYS-1:0]       r_a_frc;
    logic [TOTAL_W-1:0]          r_min [2];
    logic [TOTAL_W-1:0]          r_max [2];

    logic                        accept;
    logic                        advance;
    logic [TOTAL_W-1:0]          n_total;
    logic [TOTAL_W-1:0]          cur_min, cur_max, new_min, new_max;
    logic [TOTAL_W-1:0]          over, range_v;
    logic [TOTAL_W+3:0]          over10;
    logic                        contact;

    assign o_in_stall = r_a_vld && i_q_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign advance    = r_a_vld && !i_q_full;
    assign o_push     = advance;

    always_comb begin
        n_total = '0;
        for (int i = 0; i < USED; i++) begin
            n_total = n_total + TOTAL_W'(i_frc[i]);
        end
    end

    // tracking is updated before the contact test
    assign cur_min = r_min[r_a_foot];
    assign cur_max = r_max[r_a_foot];
    assign new_min = (r_a_total < cur_min) ? r_a_total : cur_min;
    assign new_max = (r_a_total > cur_max) ? r_a_total : cur_max;
    assign over    = r_a_total - new_min;
    assign range_v = new_max - new_min;
    assign over10  = ((TOTAL_W+4)'(over) << 3) + ((TOTAL_W+4)'(over) << 1);
    assign contact = over10 > (TOTAL_W+4)'(range_v);

    always_comb begin
        o_item.sample_valid = r_a_sv;
        o_item.foot         = r_a_foot;
        o_item.total        = r_a_sv ? r_a_total : '0;
        o_item.contact      = r_a_sv && contact;
        o_item.frc          = r_a_frc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld  <= 1'b0;
            r_min[0] <= TOTAL_INF;
            r_min[1] <= TOTAL_INF;
            r_max[0] <= '0;
            r_max[1] <= '0;
        end else begin
            if (accept) begin
                r_a_vld <= 1'b1;
            end else if (advance) begin
                r_a_vld <= 1'b0;
            end
            if (advance && r_a_sv) begin
                r_min[r_a_foot] <= new_min;
                r_max[r_a_foot] <= new_max;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_foot  <= i_foot;
            r_a_sv    <= i_sample_valid;
            r_a_total <= n_total;
            r_a_frc   <= i_frc;
        end
    end

endmodule

### design/fcc_queue.sv
// fcc_queue: short FIFO of classified samples between front and back.
// Depends on fcc_pkg.
module fcc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  fcc_pkg::t_item  i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output fcc_pkg::t_item  o_item
);
    import fcc_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_item               r_mem [Q_DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]    r_count;

    assign o_full  = r_count == CNT_W'(Q_DEPTH);
    assign o_empty = r_count == '0;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_item;
    end

endmodule

### design/fcc_back.sv
// fcc_back: serial weighted-sum MAC and restoring divider for the centre of pressure,
// plus the output register. Depends on fcc_pkg.
module fcc_back #(
    parameter int SENSORS = fcc_pkg::SENSORS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_empty,
    output logic                              o_pop,
    input  fcc_pkg::t_item                    i_item,
    input  fcc_pkg::t_hull [1:0]              i_hull,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_result_valid,
    output logic [fcc_pkg::TOTAL_W-1:0]       o_total_force,
    output logic                              o_contact,
    output logic                              o_cop_valid,
    output logic signed [fcc_pkg::COORD_W-1:0] o_cop_x,
    output logic signed [fcc_pkg::COORD_W-1:0] o_cop_y
);
    import fcc_pkg::*;

    localparam int USED   = f_used(SENSORS);
    localparam int PROD_W = COORD_W + FORCE_W + 1;
    localparam int ACC_W  = PROD_W + $clog2(USED);
    localparam int CNT_W  = $clog2(ACC_W + 1);
    localparam int REM_W  = TOTAL_W + 1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MAC  = 6'b000010,
        S_ACC  = 6'b000100,
        S_SIGN = 6'b001000,
        S_DIV  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state                    r_state;
    logic                      r_out_vld;
    t_item                     r_item;
    logic                      r_need;
    logic [SIDX_W-1:0]         r_idx;
    logic signed [PROD_W-1:0]  r_prod_x, r_prod_y;
    logic signed [ACC_W-1:0]   r_acc_x, r_acc_y;
    logic [ACC_W-1:0]          r_num_x, r_num_y;
    logic [REM_W-1:0]          r_rem_x, r_rem_y;
    logic                      r_neg_x, r_neg_y;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_out_rv, r_out_contact, r_out_cv;
    logic [TOTAL_W-1:0]        r_out_total;
    logic [COORD_W-1:0]        r_out_x, r_out_y;

    t_hull                     hull;
    logic [COORD_W-1:0]        coord_x, coord_y;
    t_force                    frc;
    logic signed [PROD_W-1:0]  m_x, m_y;
    logic [REM_W-1:0]          div, trial_x, trial_y;
    logic                      ge_x, ge_y;
    logic [ACC_W-1:0]          q_x, q_y;
    logic                      out_load;

    assign hull    = r_item.foot ? i_hull[1] : i_hull[0];
    assign coord_x = hull.x[r_idx*COORD_W +: COORD_W];
    assign coord_y = hull.y[r_idx*COORD_W +: COORD_W];
    assign frc     = r_item.frc[r_idx];
    assign m_x     = $signed(coord_x) * $signed({1'b0, frc});
    assign m_y     = $signed(coord_y) * $signed({1'b0, frc});

    // one quotient bit per cycle on the magnitudes
    assign div     = {1'b0, r_item.total};
    assign trial_x = {r_rem_x[REM_W-2:0], r_num_x[ACC_W-1]};
    assign trial_y = {r_rem_y[REM_W-2:0], r_num_y[ACC_W-1]};
    assign ge_x    = trial_x >= div;
    assign ge_y    = trial_y >= div;
    assign q_x     = r_neg_x ? -r_num_x : r_num_x;
    assign q_y     = r_neg_y ? -r_num_y : r_num_y;

    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign out_load = (r_state == S_DONE) && (!r_out_vld || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_state <= (i_item.contact && (i_item.total != '0)) ? S_MAC : S_DONE;
                    end
                end
                S_MAC: begin
                    if (r_idx == SIDX_W'(USED - 1)) r_state <= S_ACC;
                end
                S_ACC:  r_state <= S_SIGN;
                S_SIGN: r_state <= S_DIV;
                S_DIV: begin
                    if (r_cnt == CNT_W'(1)) r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_item  <= i_item;
                r_need  <= i_item.contact && (i_item.total != '0);
                r_idx   <= '0;
                r_acc_x <= '0;
                r_acc_y <= '0;
            end
            S_MAC: begin
                r_prod_x <= m_x;
                r_prod_y <= m_y;
                if (r_idx != '0) begin
                    r_acc_x <= r_acc_x + ACC_W'(r_prod_x);
                    r_acc_y <= r_acc_y + ACC_W'(r_prod_y);
                end
                r_idx <= r_idx + 1'b1;
            end
            S_ACC: begin
                r_acc_x <= r_acc_x + ACC_W'(r_prod_x);
                r_acc_y <= r_acc_y + ACC_W'(r_prod_y);
            end
            S_SIGN: begin
                r_neg_x <= r_acc_x[ACC_W-1];
                r_neg_y <= r_acc_y[ACC_W-1];
                r_num_x <= r_acc_x[ACC_W-1] ? -r_acc_x : r_acc_x;
                r_num_y <= r_acc_y[ACC_W-1] ? -r_acc_y : r_acc_y;
                r_rem_x <= '0;
                r_rem_y <= '0;
                r_cnt   <= CNT_W'(ACC_W);
            end
            S_DIV: begin
                r_rem_x <= ge_x ? trial_x - div : trial_x;
                r_rem_y <= ge_y ? trial_y - div : trial_y;
                r_num_x <= {r_num_x[ACC_W-2:0], ge_x};
                r_num_y <= {r_num_y[ACC_W-2:0], ge_y};
                r_cnt   <= r_cnt - 1'b1;
            end
            S_DONE: begin
                if (out_load) begin
                    r_out_rv      <= r_item.sample_valid;
                    r_out_total   <= r_item.total;
                    r_out_contact <= r_item.contact;
                    r_out_cv      <= r_need;
                    r_out_x       <= r_need ? q_x[COORD_W-1:0] : '0;
                    r_out_y       <= r_need ? q_y[COORD_W-1:0] : '0;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid    = r_out_vld;
    assign o_result_valid = r_out_rv;
    assign o_total_force  = r_out_total;
    assign o_contact      = r_out_contact;
    assign o_cop_valid    = r_out_cv;
    assign o_cop_x        = $signed(r_out_x);
    assign o_cop_y        = $signed(r_out_y);

    a_cop_needs_contact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_cv |-> r_out_contact && r_out_rv)
        else $error("cop_valid without contact");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt != '0))
        else $error("divider ran past its last step");

    a_pop_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == S_MAC) || (r_state == S_DONE))
        else $error("pop did not start an item");

endmodule

### test/testbench.sv
// Testbench for foot_force_contact_cop: drives force samples and hull registers and checks
// every result word against a predictor of totals, per-foot min/max tracking and pressure centre.
// Depends on fcc_pkg and foot_force_contact_cop; needs nothing else.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fcc_pkg::*;

    // one sample word as offered on the input channel
    typedef struct packed {
        logic                            foot;
        logic                            sample_valid;
        logic [MAX_PHYS-1:0][FORCE_W-1:0] frc;
    } t_sample;

    // one result word as seen on the output channel
    typedef struct packed {
        logic                      result_valid;
        logic [TOTAL_W-1:0]        total;
        logic                      contact;
        logic                      cop_valid;
        logic signed [COORD_W-1:0] cop_x;
        logic signed [COORD_W-1:0] cop_y;
    } t_cop_result;

    localparam int USED = (SENSORS_DEF < MAX_PHYS) ? SENSORS_DEF : MAX_PHYS;

    // Scoreboard: mirrors hull registers and per-foot tracking, predicts the word
    // each accepted sample produces and checks output words in order.
    class fcc_scoreboard;
        t_cop_result        due_results[$];
        logic [HULL_W-1:0]  hull[4];
        logic [TOTAL_W-1:0] min_tot[2];
        logic [TOTAL_W-1:0] max_tot[2];
        int                 errors;

        function new();
            foreach (hull[i]) hull[i] = '0;
            foreach (min_tot[i]) begin
                min_tot[i] = TOTAL_INF;
                max_tot[i] = '0;
            end
            errors = 0;
        endfunction

        task report(string msg);
            $display("ERROR @%0t: %s", $realtime, msg);
            errors++;
        endtask

        // force-weighted mean of one packed coordinate word, truncated toward zero
        function logic [COORD_W-1:0] weighted_coord(logic [HULL_W-1:0] word, t_sample s,
                                                    longint sum);
            longint acc;
            acc = 0;
            for (int i = 0; i < USED; i++)
                acc += longint'($signed(word[COORD_W*i +: COORD_W]))
                       * longint'({48'b0, s.frc[i]});
            return COORD_W'(acc / sum);
        endfunction

        function t_cop_result predict_cop(t_sample s);
            t_cop_result        r;
            logic [TOTAL_W-1:0] tot;
            longint             span, excess;
            int                 ft;
            r = '0;
            if (!s.sample_valid) return r;     // invalid: all zero, no tracking update
            ft = s.foot;
            tot = '0;
            for (int i = 0; i < USED; i++) tot += TOTAL_W'(s.frc[i]);
            if (tot < min_tot[ft]) min_tot[ft] = tot;
            if (tot > max_tot[ft]) max_tot[ft] = tot;
            // contact uses the tracking after this sample's update
            span   = longint'({46'b0, max_tot[ft]}) - longint'({46'b0, min_tot[ft]});
            excess = longint'({46'b0, tot}) - longint'({46'b0, min_tot[ft]});
            r.result_valid = 1'b1;
            r.total        = tot;
            r.contact      = (10 * excess) > span;
            if (r.contact && tot != 0) begin
                r.cop_valid = 1'b1;
                r.cop_x = weighted_coord(s.foot ? hull[REG_RIGHT_X] : hull[REG_LEFT_X], s,
                                         longint'({46'b0, tot}));
                r.cop_y = weighted_coord(s.foot ? hull[REG_RIGHT_Y] : hull[REG_LEFT_Y], s,
                                         longint'({46'b0, tot}));
            end
            return r;
        endfunction

        function void note_sample(t_sample s);
            due_results = {due_results, predict_cop(s)};
        endfunction

        task check_word(t_cop_result got);
            t_cop_result want;
            if (due_results.size() == 0) begin
                report("result word with nothing expected");
                return;
            end
            want = due_results.pop_front();
            if (got.result_valid !== want.result_valid)
                report($sformatf("result_valid %b, want %b", got.result_valid,
                                 want.result_valid));
            if (got.total !== want.total)
                report($sformatf("total_force %0d, want %0d", got.total, want.total));
            if (got.contact !== want.contact)
                report($sformatf("contact %b, want %b (total %0d)", got.contact,
                                 want.contact, want.total));
            if (got.cop_valid !== want.cop_valid)
                report($sformatf("cop_valid %b, want %b", got.cop_valid, want.cop_valid));
            if (got.cop_x !== want.cop_x)
                report($sformatf("cop_x %0d, want %0d", got.cop_x, want.cop_x));
            if (got.cop_y !== want.cop_y)
                report($sformatf("cop_y %0d, want %0d", got.cop_y, want.cop_y));
        endtask

        function int pending();
            return due_results.size();
        endfunction
    endclass

    // ---------------------------------------------------------------- clock, reset, DUT
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    always #2 i_clk = ~i_clk;

    logic                  i_in_valid     = 1'b0;
    logic                  i_foot         = 1'b0;
    logic                  i_sample_valid = 1'b0;
    logic [FORCE_W-1:0]    i_force_0      = '0;
    logic [FORCE_W-1:0]    i_force_1      = '0;
    logic [FORCE_W-1:0]    i_force_2      = '0;
    logic [FORCE_W-1:0]    i_force_3      = '0;
    logic                  i_out_stall    = 1'b0;
    logic                  psel           = 1'b0;
    logic                  penable        = 1'b0;
    logic                  pwrite         = 1'b0;
    logic [APB_AW-1:0]     paddr          = '0;
    logic [APB_DW-1:0]     pwdata         = '0;

    logic                      o_in_stall;
    logic                      o_out_valid;
    logic                      o_result_valid;
    logic [TOTAL_W-1:0]        o_total_force;
    logic                      o_contact;
    logic                      o_cop_valid;
    logic signed [COORD_W-1:0] o_cop_x;
    logic signed [COORD_W-1:0] o_cop_y;
    logic [APB_DW-1:0]         prdata;
    logic                      pready;

    foot_force_contact_cop DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_foot         (i_foot),
        .i_sample_valid (i_sample_valid),
        .i_force_0      (i_force_0),
        .i_force_1      (i_force_1),
        .i_force_2      (i_force_2),
        .i_force_3      (i_force_3),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_valid (o_result_valid),
        .o_total_force  (o_total_force),
        .o_contact      (o_contact),
        .o_cop_valid    (o_cop_valid),
        .o_cop_x        (o_cop_x),
        .o_cop_y        (o_cop_y),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    fcc_scoreboard sb = new();

    // idling switches: cleared for the long quiet stretch
    bit send_gaps  = 1'b0;
    bit out_stalls = 1'b0;

    // ---------------------------------------------------------------- output side
    // Stall is random and independent of valid; it is raised about 8 percent of the time.
    always @(posedge i_clk)
        i_out_stall <= out_stalls && ($urandom_range(99) < 8);

    t_cop_result out_word;
    assign out_word = {o_result_valid, o_total_force, o_contact, o_cop_valid, o_cop_x, o_cop_y};

    // Values read in the active region at the edge are the pre-edge ones, i.e. what
    // the handshake actually saw.
    always @(posedge i_clk)
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_word(out_word);

    // ---------------------------------------------------------------- input side
    // Offer one word, optionally after a short gap; hold it until taken.
    task automatic send_sample(input t_sample s);
        if (send_gaps && $urandom_range(99) < 8) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_foot         <= s.foot;
        i_sample_valid <= s.sample_valid;
        i_force_0      <= s.frc[0];
        i_force_1      <= s.frc[1];
        i_force_2      <= s.frc[2];
        i_force_3      <= s.frc[3];
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_sample(s);
    endtask

    function automatic t_sample mk(bit ft, bit ok, int f0, int f1, int f2, int f3);
        t_sample s;
        s.foot         = ft;
        s.sample_valid = ok;
        s.frc[0]       = FORCE_W'(f0);
        s.frc[1]       = FORCE_W'(f1);
        s.frc[2]       = FORCE_W'(f2);
        s.frc[3]       = FORCE_W'(f3);
        return s;
    endfunction

    // Mostly valid samples with full-range forces; some light ones, zeros,
    // saturated sensors and invalid reads.
    function automatic t_sample rand_sample();
        t_sample s;
        bit      light;
        s.foot         = $urandom_range(1);
        s.sample_valid = ($urandom_range(99) >= 10);
        light          = ($urandom_range(9) == 0);
        for (int i = 0; i < MAX_PHYS; i++) begin
            case ($urandom_range(9))
                0:       s.frc[i] = '0;
                1:       s.frc[i] = '1;
                2:       s.frc[i] = FORCE_W'($urandom_range(255));
                default: s.frc[i] = FORCE_W'($urandom_range(16'hFFFF));
            endcase
            if (light) s.frc[i] = FORCE_W'($urandom_range(63));
        end
        return s;
    endfunction

    // Stop sending and wait until every outstanding word has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------- config port
    // Write one hull register (setup + access), then read it back.
    task automatic cfg_write(input t_reg r, input logic [APB_DW-1:0] v);
        logic [APB_DW-1:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 3'b000};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.hull[r] = v;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== v)
            sb.report($sformatf("reg %s reads %h, want %h", r.name(), rd, v));
    endtask

    task automatic cfg_all(input logic [APB_DW-1:0] lx, ly, rx, ry);
        cfg_write(REG_LEFT_X, lx);
        cfg_write(REG_LEFT_Y, ly);
        cfg_write(REG_RIGHT_X, rx);
        cfg_write(REG_RIGHT_Y, ry);
    endtask

    task automatic run_random(input int n);
        for (int k = 0; k < n; k++) begin
            send_sample(rand_sample());
            if ($urandom_range(299) == 0) drain_results();    // occasional full pause
        end
        drain_results();
    endtask

    // ---------------------------------------------------------------- sequence
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Hulls at reset value: contact gives a centre of zero with cop_valid set.
        send_sample(mk(0, 0, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF)); // invalid read, ignored
        send_sample(mk(0, 1, 0, 0, 0, 0));                     // first left: no contact
        send_sample(mk(0, 1, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF)); // max total, contact
        send_sample(mk(1, 0, 'h5555, 'hAAAA, 'h5555, 'hAAAA)); // invalid on right foot
        drain_results();

        // Extreme coordinates on both feet.
        cfg_all(64'h7FFF_8000_7FFF_8000, 64'h8000_7FFF_8000_7FFF,
                64'hFFFF_0001_8000_7FFF, 64'h0000_0100_FF00_7FFF);
        send_sample(mk(1, 1, 0, 0, 0, 0));        // right min = max = 0
        send_sample(mk(1, 1, 1000, 0, 0, 0));     // contact, centre on sensor 0
        send_sample(mk(1, 1, 0, 100, 0, 0));      // 10*excess equals span: no contact
        send_sample(mk(1, 1, 0, 0, 101, 0));      // just over the threshold
        send_sample(mk(1, 1, 0, 0, 0, 101));
        send_sample(mk(0, 1, 'hFFFF, 0, 0, 0));   // most negative coordinate
        send_sample(mk(0, 1, 0, 'hFFFF, 0, 0));   // most positive coordinate
        send_sample(mk(0, 1, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF)); // -0.5 on both axes truncates to 0
        send_sample(mk(0, 1, 3, 1, 0, 0));        // light load: below threshold
        send_sample(mk(0, 1, 30000, 10001, 0, 0)); // negative mean with a fraction
        send_sample(mk(0, 1, 1234, 40000, 7, 'hFFFF));
        send_sample(mk(1, 0, 'hFFFF, 0, 'hFFFF, 0));
        drain_results();

        send_gaps  = 1'b1;
        out_stalls = 1'b1;
        run_random(450);

        // Long stretch without idling on either side; all coordinates -1 / 0.
        send_gaps  = 1'b0;
        out_stalls = 1'b0;
        cfg_all('1, '0, '0, '1);
        run_random(450);

        send_gaps  = 1'b1;
        out_stalls = 1'b1;
        cfg_all({$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom}, {$urandom, $urandom});
        run_random(450);

        cfg_all(64'h8000_8000_8000_8000, 64'h7FFF_7FFF_7FFF_7FFF,
                64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000);
        run_random(500);

        // allow for the deepest pipeline latency before closing out
        repeat (60) @(posedge i_clk);
        if (sb.errors == 0)
            $display("** foot_force_contact_cop: PASSED **");
        else
            $display("** foot_force_contact_cop: FAILED **");
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial begin
        #2_000_000;
        $display("ERROR: timeout with %0d words outstanding", sb.pending());
        $display("** foot_force_contact_cop: FAILED **");
        $finish;
    end

endmodule

### sim.f
design/fcc_pkg.sv
design/fcc_front.sv
design/fcc_queue.sv
design/fcc_back.sv
design/foot_force_contact_cop.sv
test/testbench.sv
